### rtl/wcc_pkg.sv
// Shared types and constants for the window color contrast block.
package wcc_pkg;

    localparam int CH_W    = 8;
    localparam int PIX_W   = 3 * CH_W;
    localparam int COORD_W = 8;
    localparam int POS_W   = 9;
    localparam int DIM_W   = 9;
    localparam int RAD_W   = 3;
    localparam int D2_W    = 18;
    localparam int ROOT_W  = 17;
    localparam int SUM_W   = 25;
    localparam int IN_W    = 40;
    localparam int OUT_W   = 32;
    localparam int ADDR_W  = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTER,
        ST_WALK,
        ST_DRAIN,
        ST_DONE
    } wcc_state_t;

endpackage

### rtl/wcc_sqrt.sv
// Pipelined integer square root of d2 * 65536, one result bit per stage.
module wcc_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [wcc_pkg::D2_W-1:0]   in_d2,
    output logic                       out_valid,
    output logic [wcc_pkg::ROOT_W-1:0] out_root,
    output logic                       busy
);
    import wcc_pkg::*;

    localparam int NS = ROOT_W;
    localparam int RW = ROOT_W + 3;
    localparam int VW = 2 * ROOT_W;

    logic [RW-1:0]     rem_reg  [NS];
    logic [ROOT_W-1:0] root_reg [NS];
    logic [VW-1:0]     v_reg    [NS];
    logic [NS-1:0]     vld_reg;

    logic [RW-1:0]     rem_next  [NS];
    logic [ROOT_W-1:0] root_next [NS];
    logic [VW-1:0]     v_next    [NS];
    logic [NS-1:0]     vld_next;

    always_comb
    begin
        logic [RW-1:0]     pr;
        logic [ROOT_W-1:0] proot;
        logic [VW-1:0]     pv;
        logic              pvld;
        logic [RW-1:0]     sh;
        logic [RW-1:0]     trial;
        for (int k = 0; k < NS; k++)
        begin
            if (k == 0)
            begin
                pr    = '0;
                proot = '0;
                pv    = {in_d2, {(VW - D2_W){1'b0}}};
                pvld  = in_valid;
            end
            else
            begin
                pr    = rem_reg[k-1];
                proot = root_reg[k-1];
                pv    = v_reg[k-1];
                pvld  = vld_reg[k-1];
            end
            sh    = {pr[RW-3:0], pv[VW-1:VW-2]};
            trial = RW'({proot, 2'b01});
            if (sh >= trial)
            begin
                rem_next[k]  = sh - trial;
                root_next[k] = {proot[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = sh;
                root_next[k] = {proot[ROOT_W-2:0], 1'b0};
            end
            v_next[k]   = {pv[VW-3:0], 2'b00};
            vld_next[k] = pvld;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            v_reg[k]    <= v_next[k];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign busy      = |vld_reg;

endmodule

### rtl/window_color_contrast_core.sv
// Window color contrast core: pixel frame store and windowed distance summing.
//
// Input stream s_*: tuser[0] is the operation. A write item stores its color
// at (row, col); writes beyond the store are dropped.
// A query item walks the clipped square window around (row, col) and returns
// one result item on m_*: tdata holds the distance sum, tuser[0] the status.
// A query outside the configured image returns status 1 and sum 0.
// A valid query does one center read, then one pixel memory read per cycle for
// each window pixel on the single read port; a 2-stage difference/square path
// and a 17-stage root pipeline then drain before the result is loaded.
// One item is worked on at a time; s_tready is high while the core is idle.
// The result register keeps its item while m_tready is low; a query's result
// waits inside the core until that register is free. Reset sets the registers
// to 256, 256, 1 and clears control state. The pixel store is not cleared:
// an entry must be written before it is read. Registers are to be written by
// the user over the APB port only while the core is idle; it is not enforced.
module window_color_contrast_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 7
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // row, col, channel_a, channel_b, channel_c
    input  logic [wcc_pkg::IN_W-1:0]    s_tdata,
    // operation
    input  logic [0:0]                  s_tuser,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // contrast_sum, zero pad
    output logic [wcc_pkg::OUT_W-1:0]   m_tdata,
    // status
    output logic [0:0]                  m_tuser,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wcc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import wcc_pkg::*;

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int W_RST  = (256 > MAX_WIDTH) ? MAX_WIDTH : 256;
    localparam int H_RST  = (256 > MAX_HEIGHT) ? MAX_HEIGHT : 256;
    localparam int R_RST  = (1 > MAX_RADIUS) ? MAX_RADIUS : 1;

    // configuration
    logic [DIM_W-1:0] width_reg, height_reg;
    logic [RAD_W-1:0] radius_reg;
    logic             cfg_we;
    logic [DIM_W-1:0] wdim;
    logic [RAD_W-1:0] wrad;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready;
    assign wdim   = pwdata[DIM_W-1:0];
    assign wrad   = pwdata[RAD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(W_RST);
            height_reg <= DIM_W'(H_RST);
            radius_reg <= RAD_W'(R_RST);
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_WIDTH:
                begin
                    if (wdim == '0)
                        width_reg <= DIM_W'(1);
                    else if (32'(wdim) > MAX_WIDTH)
                        width_reg <= DIM_W'(MAX_WIDTH);
                    else
                        width_reg <= wdim;
                end
                REG_HEIGHT:
                begin
                    if (wdim == '0)
                        height_reg <= DIM_W'(1);
                    else if (32'(wdim) > MAX_HEIGHT)
                        height_reg <= DIM_W'(MAX_HEIGHT);
                    else
                        height_reg <= wdim;
                end
                REG_RADIUS:
                begin
                    if (32'(wrad) > MAX_RADIUS)
                        radius_reg <= RAD_W'(MAX_RADIUS);
                    else
                        radius_reg <= wrad;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = 32'(width_reg);
            REG_HEIGHT: prdata = 32'(height_reg);
            REG_RADIUS: prdata = 32'(radius_reg);
            default:    prdata = '0;
        endcase
    end

    // input unpack
    logic              in_op;
    logic [COORD_W-1:0] in_row, in_col;
    logic [PIX_W-1:0]  in_pix;
    logic [POS_W-1:0]  row9, col9, rad9, hm1, wm1;
    logic [POS_W:0]    row_hi, col_hi;

    assign in_op  = s_tuser[0];
    assign in_row = s_tdata[7:0];
    assign in_col = s_tdata[15:8];
    assign in_pix = s_tdata[39:16];
    assign row9   = POS_W'(in_row);
    assign col9   = POS_W'(in_col);
    assign rad9   = POS_W'(radius_reg);
    assign hm1    = height_reg - DIM_W'(1);
    assign wm1    = width_reg - DIM_W'(1);
    assign row_hi = (POS_W+1)'(row9) + (POS_W+1)'(rad9);
    assign col_hi = (POS_W+1)'(col9) + (POS_W+1)'(rad9);

    // control state
    wcc_state_t       state_reg, state_next;
    logic [POS_W-1:0] y_reg, y_next, x_reg, x_next;
    logic [POS_W-1:0] r0_reg, r0_next, r1_reg, r1_next;
    logic [POS_W-1:0] c0_reg, c0_next, c1_reg, c1_next;
    logic             stat_reg, stat_next;
    logic             m_valid_reg, m_valid_next;
    logic [SUM_W-1:0] m_sum_reg, m_sum_next;
    logic             m_stat_reg, m_stat_next;
    logic [SUM_W-1:0] acc_reg, acc_next;
    logic             acc_clr;

    // memory
    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] mem_q;
    logic             mem_we;
    logic [AW-1:0]    waddr, raddr;

    assign waddr  = AW'(in_row) * AW'(MAX_WIDTH) + AW'(in_col);
    assign raddr  = AW'(y_reg) * AW'(MAX_WIDTH) + AW'(x_reg);
    assign mem_we = s_tvalid && s_tready && (in_op == OP_WRITE)
                    && (32'(in_row) < MAX_HEIGHT) && (32'(in_col) < MAX_WIDTH);

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= in_pix;
        mem_q <= mem[raddr];
    end

    // datapath
    logic              cen_cap_reg, rd_vld_reg, dif_vld_reg, d2_vld_reg;
    logic [PIX_W-1:0]  center_reg;
    logic [CH_W-1:0]   dif_reg [3];
    logic [D2_W-1:0]   d2_reg;
    logic [CH_W-1:0]   dif_next [3];
    logic [D2_W-1:0]   d2_next;
    logic              sq_vld, sq_busy;
    logic [ROOT_W-1:0] sq_root;
    logic [SUM_W:0]    acc_sum;

    always_comb
    begin
        logic [CH_W-1:0] a, b;
        for (int k = 0; k < 3; k++)
        begin
            a = center_reg[k*CH_W +: CH_W];
            b = mem_q[k*CH_W +: CH_W];
            dif_next[k] = (a >= b) ? a - b : b - a;
        end
        d2_next = D2_W'(dif_reg[0] * dif_reg[0]) + D2_W'(dif_reg[1] * dif_reg[1])
                + D2_W'(dif_reg[2] * dif_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (cen_cap_reg)
            center_reg <= mem_q;
        for (int k = 0; k < 3; k++)
            dif_reg[k] <= dif_next[k];
        d2_reg <= d2_next;
    end

    wcc_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_vld_reg),
        .in_d2     (d2_reg),
        .out_valid (sq_vld),
        .out_root  (sq_root),
        .busy      (sq_busy)
    );

    assign acc_sum = (SUM_W+1)'(acc_reg) + (SUM_W+1)'(sq_root);

    always_comb
    begin
        if (acc_clr)
            acc_next = '0;
        else if (sq_vld)
            acc_next = acc_sum[SUM_W] ? {SUM_W{1'b1}} : acc_sum[SUM_W-1:0];
        else
            acc_next = acc_reg;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        y_next       = y_reg;
        x_next       = x_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        c0_next      = c0_reg;
        c1_next      = c1_reg;
        stat_next    = stat_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_sum_next   = m_sum_reg;
        m_stat_next  = m_stat_reg;
        acc_clr      = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid && in_op == OP_QUERY)
                begin
                    y_next  = row9;
                    x_next  = col9;
                    r0_next = (row9 > rad9) ? row9 - rad9 : '0;
                    c0_next = (col9 > rad9) ? col9 - rad9 : '0;
                    r1_next = (row_hi < (POS_W+1)'(hm1)) ? row_hi[POS_W-1:0] : hm1;
                    c1_next = (col_hi < (POS_W+1)'(wm1)) ? col_hi[POS_W-1:0] : wm1;
                    if (row9 >= height_reg || col9 >= width_reg)
                    begin
                        stat_next  = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        stat_next  = 1'b0;
                        acc_clr    = 1'b1;
                        state_next = ST_CENTER;
                    end
                end
            end
            ST_CENTER:
            begin
                y_next     = r0_reg;
                x_next     = c0_reg;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (x_reg == c1_reg)
                begin
                    x_next = c0_reg;
                    if (y_reg == r1_reg)
                        state_next = ST_DRAIN;
                    else
                        y_next = y_reg + POS_W'(1);
                end
                else
                begin
                    x_next = x_reg + POS_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !dif_vld_reg && !d2_vld_reg && !sq_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_sum_next   = stat_reg ? '0 : acc_reg;
                    m_stat_next  = stat_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            cen_cap_reg <= 1'b0;
            rd_vld_reg  <= 1'b0;
            dif_vld_reg <= 1'b0;
            d2_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            cen_cap_reg <= (state_reg == ST_CENTER);
            rd_vld_reg  <= (state_reg == ST_WALK);
            dif_vld_reg <= rd_vld_reg;
            d2_vld_reg  <= dif_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg      <= y_next;
        x_reg      <= x_next;
        r0_reg     <= r0_next;
        r1_reg     <= r1_next;
        c0_reg     <= c0_next;
        c1_reg     <= c1_next;
        stat_reg   <= stat_next;
        m_sum_reg  <= m_sum_next;
        m_stat_reg <= m_stat_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = OUT_W'(m_sum_reg);
    assign m_tuser[0] = m_stat_reg;

`ifndef NO_ASSERTIONS
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_stat_reg) |-> (m_sum_reg == '0))
        else $error("status item with nonzero sum");

    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (y_reg <= r1_reg && x_reg <= c1_reg
                                    && x_reg >= c0_reg && y_reg >= r0_reg))
        else $error("window walk out of bounds");

    a_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (sq_vld || d2_vld_reg || rd_vld_reg) |-> (state_reg != ST_IDLE
                                                  && state_reg != ST_DONE))
        else $error("pixel in flight after window finished");
`endif

endmodule

### bench/window_color_contrast_core_tb.sv
// Testbench for window_color_contrast_core: predicted contrast sums checked per result item.
`timescale 1ns / 100ps
module window_color_contrast_core_tb;
    import wcc_pkg::*;

    localparam int SUM_SAT = 33554431;
    localparam int LIMIT_CYCLES = 2000000;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_W-1:0] s_tdata;
    logic [0:0] s_tuser;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_W-1:0] m_tdata;
    logic [0:0] m_tuser;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    window_color_contrast_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    typedef struct packed {
        logic [SUM_W-1:0] contrast_sum;
        logic status;
    } contrast_t;

    logic [PIX_W-1:0] frame [0:65535];
    bit written [0:65535];
    int unsigned img_w, img_h, radius;
    contrast_t contrast_q[$];
    int errors, cycles, n_items, n_results, n_queries;
    bit stall_on;
    int unsigned hold_cnt;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout");
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return 32'(r);
    endfunction

    function automatic contrast_t window_contrast(int unsigned row, int unsigned col);
        contrast_t res;
        int unsigned r0, r1, c0, c1;
        logic [PIX_W-1:0] ctr, px;
        longint unsigned acc, d2;
        int d;
        res = '0;
        if (row >= img_h || col >= img_w)
        begin
            res.status = 1'b1;
            return res;
        end
        r0 = row > radius ? row - radius : 0;
        r1 = (row + radius < img_h - 1) ? row + radius : img_h - 1;
        c0 = col > radius ? col - radius : 0;
        c1 = (col + radius < img_w - 1) ? col + radius : img_w - 1;
        ctr = frame[row * 256 + col];
        acc = 0;
        for (int y = r0; y <= r1; y++)
            for (int x = c0; x <= c1; x++)
            begin
                px = frame[y * 256 + x];
                d2 = 0;
                for (int k = 0; k < 3; k++)
                begin
                    d = int'(ctr[8*k +: 8]) - int'(px[8*k +: 8]);
                    d2 += 64'(d * d);
                end
                acc += 64'(root_floor(d2 << 16));
                if (acc > SUM_SAT) acc = SUM_SAT;
            end
        res.contrast_sum = SUM_W'(acc);
        return res;
    endfunction

    function automatic bit window_written(int unsigned row, int unsigned col);
        int unsigned r0, r1, c0, c1;
        if (row >= img_h || col >= img_w) return 1;
        r0 = row > radius ? row - radius : 0;
        r1 = (row + radius < img_h - 1) ? row + radius : img_h - 1;
        c0 = col > radius ? col - radius : 0;
        c1 = (col + radius < img_w - 1) ? col + radius : img_w - 1;
        for (int y = r0; y <= r1; y++)
            for (int x = c0; x <= c1; x++)
                if (!written[y * 256 + x]) return 0;
        return 1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    // s_tvalid stays high between items that follow with no gap
    task automatic send_item(logic op, int unsigned row, int unsigned col, logic [PIX_W-1:0] rgb);
        int unsigned g;
        g = gap_len();
        if (g != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {rgb[23:16], rgb[15:8], rgb[7:0], col[7:0], row[7:0]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        n_items++;
        if (op == OP_WRITE)
        begin
            frame[row * 256 + col] = rgb;
            written[row * 256 + col] = 1;
        end
        else
        begin
            contrast_q.push_back(window_contrast(row, col));
            n_queries++;
        end
    endtask

    task automatic write_pixel(int unsigned row, int unsigned col, logic [PIX_W-1:0] rgb);
        send_item(OP_WRITE, row, col, rgb);
    endtask

    task automatic query(int unsigned row, int unsigned col);
        if (window_written(row, col)) send_item(OP_QUERY, row, col, PIX_W'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (contrast_q.size() != 0) @(posedge clk);
        repeat (260) @(posedge clk);
    endtask

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        return v > hi ? hi : v;
    endfunction

    task automatic apb_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_WIDTH:  img_w = clip(value & 32'h1ff, 256);
            REG_HEIGHT: img_h = clip(value & 32'h1ff, 256);
            REG_RADIUS: radius = value & 32'h7;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned r);
        drain();
        apb_write(REG_WIDTH, w);
        apb_write(REG_HEIGHT, h);
        apb_write(REG_RADIUS, r);
    endtask

    always @(posedge clk)
    begin
        contrast_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (contrast_q.size() == 0)
            begin
                report_mismatch("unexpected result item", int'(m_tdata), 0);
            end
            else
            begin
                want = contrast_q.pop_front();
                n_results++;
                if (m_tdata[SUM_W-1:0] !== want.contrast_sum || m_tdata[OUT_W-1:SUM_W] !== '0)
                    report_mismatch("contrast_sum", int'(m_tdata), int'(want.contrast_sum));
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", int'(m_tuser[0]), int'(want.status));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!stall_on)
            m_tready <= 1'b1;
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 40)
        begin
            hold_cnt <= gap_len();
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // fill a full block so queries near the origin and corners see written pixels
    task automatic test_directed();
        for (int y = 0; y < 8; y++)
            for (int x = 0; x < 8; x++)
                write_pixel(y, x, (x + y) % 2 ? 24'hffffff : 24'h000000);
        write_pixel(255, 255, 24'hff00ff);
        write_pixel(255, 254, 24'h00ff00);
        write_pixel(254, 255, 24'h0000ff);
        write_pixel(254, 254, 24'h123456);
        query(0, 0);
        query(3, 3);
        query(255, 255);
        set_geometry(8, 8, 7);
        query(4, 4);
        query(7, 7);
        query(8, 0);
        query(0, 8);
        query(255, 255);
        set_geometry(1, 1, 0);
        query(0, 0);
        query(0, 1);
        set_geometry(0, 511, 7);
        query(0, 0);
        query(0, 1);
    endtask

    // random picture in a small image; deep windows use the largest radius
    task automatic test_random(int unsigned n, int unsigned w, int unsigned h, int unsigned r);
        int unsigned row, col;
        set_geometry(w, h, r);
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
                if (!written[y * 256 + x] || $urandom_range(0, 3) == 0)
                    write_pixel(y, x, PIX_W'($urandom));
        for (int i = 0; i < n; i++)
        begin
            row = $urandom_range(0, h + 1);
            col = $urandom_range(0, w + 1);
            if ($urandom_range(0, 3) == 0)
                write_pixel(row, col, PIX_W'($urandom));
            else
                query(row, col);
            if (i == n / 2)
                drain();
        end
    endtask

    task automatic test_store_edges();
        set_geometry(256, 256, 1);
        for (int i = 0; i < 20; i++)
            write_pixel($urandom_range(0, 255), $urandom_range(0, 255), PIX_W'($urandom));
        for (int i = 0; i < 20; i++)
            query($urandom_range(0, 255), $urandom_range(0, 255));
        query(255, 255);
        query(254, 254);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = '0;
        m_tready = 1'b1; stall_on = 0; hold_cnt = 0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; cycles = 0; n_items = 0; n_results = 0; n_queries = 0;
        img_w = 256; img_h = 256; radius = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_on = 1;
        test_random(100, 12, 10, 2);
        test_random(60, 20, 16, 7);
        stall_on = 0;
        test_random(70, 6, 5, 3);
        stall_on = 1;
        test_random(70, 9, 14, 0);
        test_store_edges();
        drain();
        $display("covered %0d items, %0d queries, %0d results checked", n_items, n_queries,
            n_results);
        $display("radius 0..7, image sizes 1..256, clipping and out-of-image queries");
        if (errors == 0 && contrast_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
